@@ hw/rtl/fpp_pkg.sv @@
// Shared types, character codes and piece lookup for the board text parser.
`default_nettype none

package fpp_pkg;

  // Board slots: 0-5 white pieces, 6-11 black pieces, then color and all boards.
  localparam int unsigned SlotCount = 15;
  localparam logic [3:0] WhiteSlot = 4'd12;
  localparam logic [3:0] BlackSlot = 4'd13;
  localparam logic [3:0] AllSlot   = 4'd14;
  localparam logic [3:0] LastSlot  = 4'd14;

  localparam logic [7:0] StartSquare = 8'd56;
  localparam logic [7:0] RankStep    = 8'd16;

  // Field numbers within the text.
  localparam logic [2:0] FieldPlace  = 3'd0;
  localparam logic [2:0] FieldTurn   = 3'd1;
  localparam logic [2:0] FieldCastle = 3'd2;
  localparam logic [2:0] FieldEp     = 3'd3;
  localparam logic [2:0] FieldFifty  = 3'd4;
  localparam logic [2:0] FieldMove   = 3'd5;

  // Castling right bits.
  localparam logic [3:0] CastleWk  = 4'b0010;
  localparam logic [3:0] CastleWq  = 4'b0001;
  localparam logic [3:0] CastleBk  = 4'b1000;
  localparam logic [3:0] CastleBq  = 4'b0100;
  localparam logic [3:0] CastleAll = 4'd15;

  // ASCII codes.
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowH  = 8'h68;
  localparam logic [7:0] ChW     = 8'h77;

  typedef logic [14:0][63:0] boards_t;

  typedef struct packed {
    logic       vld;
    logic [3:0] slot;
  } piece_t;

  // Scalar fields handed from the parser to the output sequencer.
  typedef struct packed {
    logic [3:0] castle_acc;
    logic [2:0] castle_len;
    logic [7:0] ep_bits;
    logic       black_moves;
    logic       error_flag;
  } scal_t;

  function automatic piece_t piece_lookup(logic [7:0] c);
    piece_t p;
    p.vld = 1'b1;
    case (c)
      8'h4b: p.slot = 4'd0;   // K
      8'h50: p.slot = 4'd1;   // P
      8'h42: p.slot = 4'd2;   // B
      8'h4e: p.slot = 4'd3;   // N
      8'h52: p.slot = 4'd4;   // R
      8'h51: p.slot = 4'd5;   // Q
      8'h6b: p.slot = 4'd6;   // k
      8'h70: p.slot = 4'd7;   // p
      8'h62: p.slot = 4'd8;   // b
      8'h6e: p.slot = 4'd9;   // n
      8'h72: p.slot = 4'd10;  // r
      8'h71: p.slot = 4'd11;  // q
      default: begin
        p.vld  = 1'b0;
        p.slot = 4'd0;
      end
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fpp_parser.sv @@
// Per-character parse state and its update on each accepted character.
`default_nettype none

module fpp_parser #(
  parameter int unsigned CB = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic [7:0]           char_i,
  input  wire logic                 last_i,
  output fpp_pkg::boards_t          snap_boards_o,
  output fpp_pkg::scal_t            snap_scal_o,
  output logic [CB-1:0]             snap_fullmove_o,
  output logic [CB-1:0]             snap_fifty_o
);

  logic [7:0]       square_q, square_d;
  logic [2:0]       field_q, field_d;
  fpp_pkg::boards_t boards_q, boards_d;
  logic [3:0]       castle_acc_q, castle_acc_d;
  logic [2:0]       castle_len_q, castle_len_d;
  logic [7:0]       ep_bits_q, ep_bits_d;
  logic             ep_seen_q, ep_seen_d;
  logic             black_q, black_d;
  logic [CB-1:0]    fullmove_q, fullmove_d;
  logic [CB-1:0]    fifty_q, fifty_d;
  logic             err_q, err_d;
  logic [1:0]       turn_len_q, turn_len_d;
  logic             move_digits_q, move_digits_d;
  logic             move_done_q, move_done_d;

  fpp_pkg::piece_t  piece;
  logic [63:0]      sq_bit;
  logic             is_digit;
  logic [3:0]       digit;
  logic [3:0]       color_slot;

  // Appends one decimal digit, saturating at the counter's top value.
  function automatic logic [CB-1:0] dec_push(logic [CB-1:0] acc, logic [3:0] dig);
    logic [CB+3:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{CB{1'b0}}, dig};
    return (v[CB+3:CB] != 4'd0) ? {CB{1'b1}} : v[CB-1:0];
  endfunction

  always_comb begin
    square_d      = square_q;
    field_d       = field_q;
    boards_d      = boards_q;
    castle_acc_d  = castle_acc_q;
    castle_len_d  = castle_len_q;
    ep_bits_d     = ep_bits_q;
    ep_seen_d     = ep_seen_q;
    black_d       = black_q;
    fullmove_d    = fullmove_q;
    fifty_d       = fifty_q;
    err_d         = err_q;
    turn_len_d    = turn_len_q;
    move_digits_d = move_digits_q;
    move_done_d   = move_done_q;

    piece      = fpp_pkg::piece_lookup(char_i);
    sq_bit     = 64'd1 << square_q[5:0];
    is_digit   = char_i inside {[fpp_pkg::ChZero:fpp_pkg::ChNine]};
    digit      = is_digit ? 4'(char_i - fpp_pkg::ChZero) : 4'd0;
    color_slot = (piece.slot < 4'd6) ? fpp_pkg::WhiteSlot : fpp_pkg::BlackSlot;

    if (char_i == fpp_pkg::ChSpace && field_q < fpp_pkg::FieldMove) begin
      field_d = field_q + 3'd1;
      if (field_q == fpp_pkg::FieldPlace) begin
        black_d = 1'b1;
      end
    end else begin
      case (field_q)
        fpp_pkg::FieldPlace: begin
          if (char_i == fpp_pkg::ChSlash) begin
            square_d = square_q - fpp_pkg::RankStep;
          end else if (char_i inside {[fpp_pkg::ChOne:fpp_pkg::ChNine]}) begin
            square_d = square_q + (char_i - fpp_pkg::ChZero);
          end else if (!piece.vld) begin
            err_d = 1'b1;
          end else begin
            if (square_q < 8'd64) begin
              boards_d[piece.slot]       = boards_d[piece.slot] ^ sq_bit;
              boards_d[color_slot]       = boards_d[color_slot] ^ sq_bit;
              boards_d[fpp_pkg::AllSlot] = boards_d[fpp_pkg::AllSlot] ^ sq_bit;
            end else begin
              err_d = 1'b1;
            end
            square_d = square_q + 8'd1;
          end
        end
        fpp_pkg::FieldTurn: begin
          black_d = !(turn_len_q == 2'd0 && char_i == fpp_pkg::ChW);
          if (turn_len_q != 2'd3) begin
            turn_len_d = turn_len_q + 2'd1;
          end
        end
        fpp_pkg::FieldCastle: begin
          if (castle_len_q < 3'd3) begin
            case (char_i)
              8'h4b:   castle_acc_d = castle_acc_q ^ fpp_pkg::CastleWk;
              8'h51:   castle_acc_d = castle_acc_q ^ fpp_pkg::CastleWq;
              8'h6b:   castle_acc_d = castle_acc_q ^ fpp_pkg::CastleBk;
              8'h71:   castle_acc_d = castle_acc_q ^ fpp_pkg::CastleBq;
              default: castle_acc_d = castle_acc_q;
            endcase
          end
          if (castle_len_q != 3'd7) begin
            castle_len_d = castle_len_q + 3'd1;
          end
        end
        fpp_pkg::FieldEp: begin
          if (!ep_seen_q) begin
            ep_seen_d = 1'b1;
            ep_bits_d = (char_i inside {[fpp_pkg::ChLowA:fpp_pkg::ChLowH]})
                      ? (8'd1 << 3'(char_i - fpp_pkg::ChLowA)) : 8'd0;
          end
        end
        fpp_pkg::FieldFifty: begin
          fifty_d = dec_push(fifty_q, digit);
        end
        default: begin
          if (!move_done_q) begin
            if (is_digit) begin
              fullmove_d    = dec_push(fullmove_q, digit);
              move_digits_d = 1'b1;
            end else if (!(char_i == fpp_pkg::ChSpace && !move_digits_q)) begin
              move_done_d = 1'b1;
            end
          end
        end
      endcase
    end
  end

  assign snap_boards_o            = boards_d;
  assign snap_scal_o.castle_acc   = castle_acc_d;
  assign snap_scal_o.castle_len   = castle_len_d;
  assign snap_scal_o.ep_bits      = ep_bits_d;
  assign snap_scal_o.black_moves  = black_d;
  assign snap_scal_o.error_flag   = err_d;
  assign snap_fullmove_o          = fullmove_d;
  assign snap_fifty_o             = fifty_d;

  // The final character of a text returns every register to its start value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      square_q      <= fpp_pkg::StartSquare;
      field_q       <= fpp_pkg::FieldPlace;
      boards_q      <= '0;
      castle_acc_q  <= '0;
      castle_len_q  <= '0;
      ep_bits_q     <= '0;
      ep_seen_q     <= 1'b0;
      black_q       <= 1'b0;
      fullmove_q    <= '0;
      fifty_q       <= '0;
      err_q         <= 1'b0;
      turn_len_q    <= '0;
      move_digits_q <= 1'b0;
      move_done_q   <= 1'b0;
    end else if (step_i && last_i) begin
      square_q      <= fpp_pkg::StartSquare;
      field_q       <= fpp_pkg::FieldPlace;
      boards_q      <= '0;
      castle_acc_q  <= '0;
      castle_len_q  <= '0;
      ep_bits_q     <= '0;
      ep_seen_q     <= 1'b0;
      black_q       <= 1'b0;
      fullmove_q    <= '0;
      fifty_q       <= '0;
      err_q         <= 1'b0;
      turn_len_q    <= '0;
      move_digits_q <= 1'b0;
      move_done_q   <= 1'b0;
    end else if (step_i) begin
      square_q      <= square_d;
      field_q       <= field_d;
      boards_q      <= boards_d;
      castle_acc_q  <= castle_acc_d;
      castle_len_q  <= castle_len_d;
      ep_bits_q     <= ep_bits_d;
      ep_seen_q     <= ep_seen_d;
      black_q       <= black_d;
      fullmove_q    <= fullmove_d;
      fifty_q       <= fifty_d;
      err_q         <= err_d;
      turn_len_q    <= turn_len_d;
      move_digits_q <= move_digits_d;
      move_done_q   <= move_done_d;
    end
  end

  a_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_q <= fpp_pkg::FieldMove)
    else $error("field number beyond the last field");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> square_q == fpp_pkg::StartSquare && boards_q == '0 && !err_q)
    else $error("parse state not cleared after the final character");

endmodule

`default_nettype wire

@@ hw/rtl/fpp_emitter.sv @@
// Snapshot of a finished parse and the fifteen-beat result sequencer.
`default_nettype none

module fpp_emitter #(
  parameter int unsigned CB = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire fpp_pkg::boards_t boards_i,
  input  wire fpp_pkg::scal_t   scal_i,
  input  wire logic [CB-1:0]    fullmove_i,
  input  wire logic [CB-1:0]    fifty_i,
  output logic                  load_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [3:0]            board_slot_o,
  output logic [63:0]           board_bits_o,
  output logic [3:0]            castle_rights_o,
  output logic [7:0]            ep_files_o,
  output logic [15:0]           half_move_o,
  output logic [15:0]           fifty_clock_o,
  output logic                  parse_error_o,
  output logic                  run_last_o
);

  localparam logic [32:0] HalfLim = (CB >= 16) ? 33'h0ffff : ((33'd1 << CB) - 33'd1);

  logic             busy_q, busy_d;
  logic [3:0]       slot_q, slot_d;
  fpp_pkg::boards_t boards_q;
  fpp_pkg::scal_t   scal_q;
  logic [CB-1:0]    fullmove_q;
  logic [CB-1:0]    fifty_q;
  logic             fire;
  logic             final_beat;
  logic [32:0]      half_wide;
  logic [32:0]      fifty_wide;

  assign fire         = busy_q && out_ready_i;
  assign final_beat   = slot_q == fpp_pkg::LastSlot;
  assign load_ready_o = !busy_q || (out_ready_i && final_beat);

  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    if (load_i) begin
      busy_d = 1'b1;
      slot_d = 4'd0;
    end else if (fire) begin
      if (final_beat) begin
        busy_d = 1'b0;
      end
      slot_d = slot_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= 4'd0;
    end else begin
      busy_q <= busy_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      boards_q   <= boards_i;
      scal_q     <= scal_i;
      fullmove_q <= fullmove_i;
      fifty_q    <= fifty_i;
    end
  end

  // Half moves are twice the completed full moves plus one when black is to move.
  always_comb begin
    half_wide  = (fullmove_q == '0) ? 33'd0 : 33'({CB'(fullmove_q - 1'b1), scal_q.black_moves});
    fifty_wide = 33'(fifty_q);
  end

  assign out_valid_o     = busy_q;
  assign board_slot_o    = slot_q;
  assign board_bits_o    = boards_q[slot_q];
  assign castle_rights_o = (scal_q.castle_len == 3'd4) ? fpp_pkg::CastleAll : scal_q.castle_acc;
  assign ep_files_o      = scal_q.ep_bits;
  assign half_move_o     = (half_wide > HalfLim) ? HalfLim[15:0] : half_wide[15:0];
  assign fifty_clock_o   = (fifty_wide > 33'h0ffff) ? 16'hffff : fifty_wide[15:0];
  assign parse_error_o   = scal_q.error_flag;
  assign run_last_o      = final_beat;

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> slot_q <= fpp_pkg::LastSlot)
    else $error("result slot beyond the last board");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> busy_q && slot_q == 4'd0)
    else $error("snapshot load did not start a run at slot zero");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> load_ready_o)
    else $error("snapshot loaded while a run is still in flight");

endmodule

`default_nettype wire

@@ hw/rtl/fen_position_parser.sv @@
// Top level of the chess board text parser: input register, parser and result sequencer.
`default_nettype none

// The block reads a chess board description one character per transfer and, on
// the character marked as last, produces fifteen result transfers: one bitboard per
// slot (twelve piece boards, the two color boards and the all-pieces board), each
// carrying the same castling rights, en-passant file, half-move count, fifty-move
// clock and error flag, with run_last high on slot 14. Characters are taken at one
// per cycle unless a final character waits; each passes an input register and is
// folded into the parse state when the parser steps. The final character copies
// the finished position into a result snapshot and returns the parse state to its
// start, so the next text can stream in while the fifteen results drain. The drain
// of that single snapshot is the only limit: a final character waits in the input
// register until the previous run is on its last result transfer, so texts shorter
// than fifteen characters are paced by the result drain. COUNTER_BITS sizes the
// fullmove and fifty-move accumulators (8 to 32); both saturate at their top value
// and the reported counts are clamped to 16 bits.
module fen_position_parser #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  text_char_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       board_slot_o,
  output logic [63:0]      board_bits_o,
  output logic [3:0]       castle_rights_o,
  output logic [7:0]       ep_files_o,
  output logic [15:0]      half_move_o,
  output logic [15:0]      fifty_clock_o,
  output logic             parse_error_o,
  output logic             run_last_o
);

  logic                    in_vld_q;
  logic [7:0]              char_q;
  logic                    last_q;
  logic                    step;
  logic                    load_ready;
  fpp_pkg::boards_t        snap_boards;
  fpp_pkg::scal_t          snap_scal;
  logic [COUNTER_BITS-1:0] snap_fullmove;
  logic [COUNTER_BITS-1:0] snap_fifty;

  // A registered character is consumed unless it is final and the sequencer cannot take a new snapshot.
  assign step       = in_vld_q && (!last_q || load_ready);
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= text_char_i;
      last_q <= end_of_text_i;
    end
  end

  fpp_parser #(
    .CB (COUNTER_BITS)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .char_i          (char_q),
    .last_i          (last_q),
    .snap_boards_o   (snap_boards),
    .snap_scal_o     (snap_scal),
    .snap_fullmove_o (snap_fullmove),
    .snap_fifty_o    (snap_fifty)
  );

  fpp_emitter #(
    .CB (COUNTER_BITS)
  ) u_emitter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (step && last_q),
    .boards_i        (snap_boards),
    .scal_i          (snap_scal),
    .fullmove_i      (snap_fullmove),
    .fifty_i         (snap_fifty),
    .load_ready_o    (load_ready),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .board_slot_o    (board_slot_o),
    .board_bits_o    (board_bits_o),
    .castle_rights_o (castle_rights_o),
    .ep_files_o      (ep_files_o),
    .half_move_o     (half_move_o),
    .fifty_clock_o   (fifty_clock_o),
    .parse_error_o   (parse_error_o),
    .run_last_o      (run_last_o)
  );

  // A held character must stay in place until the parser consumes it.
  a_hold_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !step |=> in_vld_q && $stable(char_q) && $stable(last_q))
    else $error("pending character lost before it was parsed");

endmodule

`default_nettype wire
